[rtl/pbf_pkg.sv]
// ----------------------------------------------------------------------------
// pbf_pkg: shared constants and types
// Geometry limits, field widths, register indexes and the command/status
// structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package pbf_pkg;

  localparam int MAX_BITS   = 65536;
  localparam int MAX_PROBES = 16;
  localparam int MIN_BITS   = 16;

  localparam int HASH_W        = 32;
  localparam int COUNT_W       = 32;
  localparam int NUM_HASHES_W  = 5;
  localparam int FILTER_BITS_W = 17;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = FILTER_BITS_W;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_HASHES  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_BITS = CFG_IDX_W'(1);

  localparam logic [NUM_HASHES_W-1:0]  NUM_HASHES_RST  = NUM_HASHES_W'(4);
  localparam logic [FILTER_BITS_W-1:0] FILTER_BITS_RST = FILTER_BITS_W'(65536);

  localparam logic OP_QUERY = 1'b0;
  localparam logic OP_ADD   = 1'b1;

  localparam int ADDR_W  = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;
  localparam int SLOT_W  = $clog2(MAX_BITS + 1);
  localparam int KCNT_W  = $clog2(MAX_PROBES + 1);
  localparam int PROBE_W = (MAX_PROBES > 1) ? $clog2(MAX_PROBES) : 1;

  // Divider retires this many quotient bits per cycle.
  localparam int DIV_BITS_PER_CYC = 4;
  localparam int DIV_CYCLES       = HASH_W / DIV_BITS_PER_CYC;
  localparam int DIV_CNT_W        = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  typedef struct packed {
    logic load;        // latch a new item, restart probe sequence
    logic slot_start;  // divide filter bits by probe count
    logic slot_load;   // capture slot width from divider
    logic probe_start; // divide probe hash by slot width
    logic rd;          // form probe index, read store
    logic check;       // fold read bit into all-set flag
    logic next;        // advance to next probe
    logic rewind;      // back to probe zero
    logic wr;          // set the bit of the current probe
    logic count;       // bump saturating add count
    logic clr;         // clearing-pass write
    logic out_load;    // load the result register
  } pbf_cmd_t;

  typedef struct packed {
    logic div_done;
    logic last_probe;
    logic add_new;
    logic clr_last;
    logic out_full;
  } pbf_stat_t;

endpackage

[rtl/pbf_if.sv]
// ----------------------------------------------------------------------------
// pbf_if: valid/ready channels
// Request channel (operation and two key hashes) and result channel.
// ----------------------------------------------------------------------------
interface pbf_in_if;
  import pbf_pkg::*;
  logic              valid;
  logic              ready;
  logic              op;
  logic [HASH_W-1:0] hash_a;
  logic [HASH_W-1:0] hash_b;

  modport source (output valid, output op, output hash_a, output hash_b, input ready);
  modport sink   (input valid, input op, input hash_a, input hash_b, output ready);
endinterface

interface pbf_out_if;
  import pbf_pkg::*;
  logic               valid;
  logic               ready;
  logic               outcome;
  logic [COUNT_W-1:0] added_total;

  modport source (output valid, output outcome, output added_total, input ready);
  modport sink   (input valid, input outcome, input added_total, output ready);
endinterface

[rtl/pbf_div.sv]
// ----------------------------------------------------------------------------
// pbf_div: iterative restoring divider
// Unsigned 32-bit dividend by a slot-wide divisor, a few quotient bits per
// cycle. Gives quotient and remainder; done pulses for one cycle.
// ----------------------------------------------------------------------------
module pbf_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [pbf_pkg::HASH_W-1:0] dividend_i,
  input  logic [pbf_pkg::SLOT_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [pbf_pkg::HASH_W-1:0] quotient_o,
  output logic [pbf_pkg::SLOT_W-1:0] remainder_o
);
  import pbf_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [SLOT_W-1:0]    div_q;
  logic [SLOT_W-1:0]    rem_q, rem_d;
  logic [HASH_W-1:0]    quo_q, quo_d;

  // quo_q shifts dividend bits out at the top and quotient bits in at the bottom
  always_comb begin
    logic [SLOT_W:0]   r;
    logic [HASH_W-1:0] q;
    r = {1'b0, rem_q};
    q = quo_q;
    for (int j = 0; j < DIV_BITS_PER_CYC; j++) begin
      r = {r[SLOT_W-1:0], q[HASH_W-1]};
      q = {q[HASH_W-2:0], 1'b0};
      if (r >= {1'b0, div_q}) begin
        r    = r - {1'b0, div_q};
        q[0] = 1'b1;
      end
    end
    rem_d = r[SLOT_W-1:0];
    quo_d = q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(DIV_CYCLES - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= divisor_i;
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider restarted while busy");

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (rem_q < div_q))
    else $error("remainder not below divisor");

endmodule

[rtl/pbf_datapath.sv]
// ----------------------------------------------------------------------------
// pbf_datapath: filter datapath
// Config registers, item registers, probe hash and index forming, the bit
// store, saturating add count and the result register.
// ----------------------------------------------------------------------------
module pbf_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pbf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pbf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                          op_i,
  input  logic [pbf_pkg::HASH_W-1:0]     hash_a_i,
  input  logic [pbf_pkg::HASH_W-1:0]     hash_b_i,
  input  pbf_pkg::pbf_cmd_t             cmd_i,
  output pbf_pkg::pbf_stat_t            stat_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic                          outcome_o,
  output logic [pbf_pkg::COUNT_W-1:0]    added_total_o
);
  import pbf_pkg::*;

  logic [NUM_HASHES_W-1:0]  num_hashes_q;
  logic [FILTER_BITS_W-1:0] filter_bits_q;
  logic [KCNT_W-1:0]        k_eff;
  logic [SLOT_W-1:0]        bits_eff;

  logic                     op_q;
  logic [HASH_W-1:0]        hash_a_q, hash_b_q;
  logic [SLOT_W-1:0]        slot_q;
  logic [SLOT_W-1:0]        base_q;
  logic [PROBE_W-1:0]       probe_q;
  logic                     all_set_q;
  logic [COUNT_W-1:0]       count_q;
  logic [ADDR_W-1:0]        idx_q [MAX_PROBES];
  logic [ADDR_W-1:0]        clr_cnt_q;

  logic                     out_valid_q;
  logic                     outcome_q;
  logic [COUNT_W-1:0]       total_q;

  logic                     filter_mem [MAX_BITS];
  logic                     rd_data_q;

  logic [HASH_W-1:0]        probe_hash;
  logic [HASH_W-1:0]        div_dividend;
  logic [SLOT_W-1:0]        div_divisor;
  logic                     div_done;
  logic [HASH_W-1:0]        div_quo;
  logic [SLOT_W-1:0]        div_rem;
  logic [ADDR_W-1:0]        idx_now;
  logic                     mem_we;
  logic [ADDR_W-1:0]        mem_waddr;
  logic                     mem_wdata;

  // Out-of-range settings act as the nearest legal value.
  always_comb begin
    if (num_hashes_q == '0) begin
      k_eff = KCNT_W'(1);
    end else if (int'(num_hashes_q) > MAX_PROBES) begin
      k_eff = KCNT_W'(MAX_PROBES);
    end else begin
      k_eff = KCNT_W'(num_hashes_q);
    end
    if (int'(filter_bits_q) < MIN_BITS) begin
      bits_eff = SLOT_W'(MIN_BITS);
    end else if (int'(filter_bits_q) > MAX_BITS) begin
      bits_eff = SLOT_W'(MAX_BITS);
    end else begin
      bits_eff = SLOT_W'(filter_bits_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_hashes_q  <= NUM_HASHES_RST;
      filter_bits_q <= FILTER_BITS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_NUM_HASHES:  num_hashes_q  <= cfg_data_i[NUM_HASHES_W-1:0];
        REG_FILTER_BITS: filter_bits_q <= cfg_data_i[FILTER_BITS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (probe_q == PROBE_W'(0)) begin
      probe_hash = hash_a_q;
    end else if (probe_q == PROBE_W'(1)) begin
      probe_hash = hash_b_q;
    end else begin
      probe_hash = hash_b_q + hash_a_q + HASH_W'(probe_q);
    end
  end

  assign div_dividend = cmd_i.slot_start ? HASH_W'(bits_eff) : probe_hash;
  assign div_divisor  = cmd_i.slot_start ? SLOT_W'(k_eff) : slot_q;

  pbf_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.slot_start | cmd_i.probe_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // probe base plus remainder stays below the bits in use
  assign idx_now = ADDR_W'(base_q + div_rem);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q   <= '0;
      all_set_q <= 1'b1;
      count_q   <= '0;
      clr_cnt_q <= '0;
    end else begin
      if (cmd_i.load) begin
        probe_q   <= '0;
        all_set_q <= 1'b1;
      end else begin
        if (cmd_i.check) begin
          all_set_q <= all_set_q & rd_data_q;
        end
        if (cmd_i.rewind) begin
          probe_q <= '0;
        end else if (cmd_i.next) begin
          probe_q <= probe_q + PROBE_W'(1);
        end
      end
      if (cmd_i.count && (count_q != '1)) begin
        count_q <= count_q + COUNT_W'(1);
      end
      if (cmd_i.clr) begin
        clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= op_i;
      hash_a_q <= hash_a_i;
      hash_b_q <= hash_b_i;
      base_q   <= '0;
    end else if (cmd_i.rewind) begin
      base_q <= '0;
    end else if (cmd_i.next) begin
      base_q <= base_q + slot_q;
    end
    if (cmd_i.slot_load) begin
      slot_q <= div_quo[SLOT_W-1:0];
    end
    if (cmd_i.rd) begin
      idx_q[probe_q] <= idx_now;
    end
  end

  assign mem_we    = cmd_i.clr | cmd_i.wr;
  assign mem_waddr = cmd_i.clr ? clr_cnt_q : idx_q[probe_q];
  assign mem_wdata = !cmd_i.clr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      filter_mem[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.rd) begin
      rd_data_q <= filter_mem[idx_now];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      outcome_q <= (op_q == OP_ADD) ? !all_set_q : all_set_q;
      total_q   <= count_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign outcome_o     = outcome_q;
  assign added_total_o = total_q;

  assign stat_o.div_done   = div_done;
  assign stat_o.last_probe = (KCNT_W'(probe_q) == (k_eff - KCNT_W'(1)));
  assign stat_o.add_new    = (op_q == OP_ADD) && !all_set_q;
  assign stat_o.clr_last   = (clr_cnt_q == ADDR_W'(MAX_BITS - 1));
  assign stat_o.out_full   = out_valid_q && !out_ready_i;

  a_idx_in_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd |-> (SLOT_W'(idx_now) < bits_eff))
    else $error("probe index beyond filter bits in use");

  a_count_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(cmd_i.clr) |-> (count_q >= $past(count_q)))
    else $error("add count went backwards");

endmodule

[rtl/pbf_ctrl.sv]
// ----------------------------------------------------------------------------
// pbf_ctrl: filter controller
// Sequences store clear, slot division, per-probe modulo and read, the
// optional set pass for a new add, and the hand-off to the result register.
// ----------------------------------------------------------------------------
module pbf_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  pbf_pkg::pbf_stat_t stat_i,
  output pbf_pkg::pbf_cmd_t  cmd_o
);
  import pbf_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SLOT,
    ST_SLOT_WAIT,
    ST_PROBE,
    ST_PROBE_WAIT,
    ST_CHECK,
    ST_DECIDE,
    ST_WRITE,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (stat_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SLOT;
        end
      end
      ST_SLOT: begin
        cmd_o.slot_start = 1'b1;
        state_d          = ST_SLOT_WAIT;
      end
      ST_SLOT_WAIT: begin
        if (stat_i.div_done) begin
          cmd_o.slot_load = 1'b1;
          state_d         = ST_PROBE;
        end
      end
      ST_PROBE: begin
        cmd_o.probe_start = 1'b1;
        state_d           = ST_PROBE_WAIT;
      end
      ST_PROBE_WAIT: begin
        if (stat_i.div_done) begin
          cmd_o.rd = 1'b1;
          state_d  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
        if (stat_i.last_probe) begin
          cmd_o.rewind = 1'b1;
          state_d      = ST_DECIDE;
        end else begin
          cmd_o.next = 1'b1;
          state_d    = ST_PROBE;
        end
      end
      ST_DECIDE: begin
        state_d = stat_i.add_new ? ST_WRITE : ST_FINISH;
      end
      ST_WRITE: begin
        cmd_o.wr   = 1'b1;
        cmd_o.next = 1'b1;
        if (stat_i.last_probe) begin
          cmd_o.count = 1'b1;
          state_d     = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!stat_i.out_full) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/partitioned_bloom_filter.sv]
// ----------------------------------------------------------------------------
// partitioned_bloom_filter: partitioned Bloom filter with double hashing
// A request runs a slot division, then per probe a divide and a store read, and
//   a set pass for an add that sets bits; the shared divider sets the per-probe cost.
// Throughput: one transaction at a time; the next request is taken once the
//   previous result sits in the output register.
// Reset: a clearing pass writes all 65536 store bits, one per cycle, before
//   the first request is taken; config writes are accepted throughout.
// ----------------------------------------------------------------------------
module partitioned_bloom_filter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pbf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pbf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  pbf_in_if.sink                        in_i,
  pbf_out_if.source                     out_o
);
  import pbf_pkg::*;

  pbf_cmd_t  cmd;
  pbf_stat_t stat;

  pbf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pbf_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .op_i          (in_i.op),
    .hash_a_i      (in_i.hash_a),
    .hash_b_i      (in_i.hash_b),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .outcome_o     (out_o.outcome),
    .added_total_o (out_o.added_total)
  );

endmodule

[sim/partitioned_bloom_filter_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// partitioned_bloom_filter_test: self-checking testbench
// A directed table covers the hash and register extremes and out-of-range
// geometry. Random phases follow, each with its own geometry and idling,
// mixing adds, repeat adds and queries of known keys, near misses and noise.
// Results are scored in order against a shadow copy of the filter.
// ----------------------------------------------------------------------------
module partitioned_bloom_filter_test;
  import pbf_pkg::*;

  localparam int unsigned TIMEOUT_CYCLES = 2_000_000;
  localparam int DRAIN_CYCLES    = 256;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int MAX_REPORTS     = 10;
  localparam int KEY_POOL_DEPTH  = 64;
  localparam int DIRECTED_ROWS   = 31;

  typedef struct packed {
    logic               outcome;
    logic [COUNT_W-1:0] added_total;
  } lookup_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e               kind;
    logic                    op;
    logic [HASH_W-1:0]       hash_a;
    logic [HASH_W-1:0]       hash_b;
    logic [CFG_IDX_W-1:0]    reg_idx;
    logic [CFG_DATA_W-1:0]   reg_data;
    bit                      known;
    lookup_result_t          golden;
  } stim_row_t;

  // Known results only where they follow directly from an empty filter.
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{ROW_ITEM, OP_QUERY, 32'h0000_0000, 32'h0000_0000, '0, '0, 1'b1, '{1'b0, 32'd0}},
    '{ROW_ITEM, OP_ADD,   32'h0000_0000, 32'h0000_0000, '0, '0, 1'b1, '{1'b1, 32'd1}},
    '{ROW_ITEM, OP_ADD,   32'h0000_0000, 32'h0000_0000, '0, '0, 1'b1, '{1'b0, 32'd1}},
    '{ROW_ITEM, OP_QUERY, 32'h0000_0000, 32'h0000_0000, '0, '0, 1'b1, '{1'b1, 32'd1}},
    '{ROW_ITEM, OP_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, '0, 1'b1, '{1'b0, 32'd1}},
    '{ROW_ITEM, OP_ADD,   32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, '0, 1'b1, '{1'b1, 32'd2}},
    '{ROW_ITEM, OP_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, '0, 1'b1, '{1'b1, 32'd2}},
    '{ROW_ITEM, OP_ADD,   32'h8000_0000, 32'h7FFF_FFFF, '0, '0, 1'b0, '0},
    '{ROW_CFG,  OP_QUERY, '0, '0, REG_NUM_HASHES,  17'd0,       1'b0, '0},
    '{ROW_ITEM, OP_QUERY, 32'h0000_0000, 32'h0000_0000, '0, '0, 1'b0, '0},
    '{ROW_ITEM, OP_ADD,   32'h0000_0001, 32'hFFFF_FFFE, '0, '0, 1'b0, '0},
    '{ROW_CFG,  OP_QUERY, '0, '0, REG_NUM_HASHES,  17'd31,      1'b0, '0},
    '{ROW_ITEM, OP_ADD,   32'h1234_5678, 32'h9ABC_DEF0, '0, '0, 1'b0, '0},
    '{ROW_ITEM, OP_QUERY, 32'h1234_5678, 32'h9ABC_DEF0, '0, '0, 1'b0, '0},
    '{ROW_CFG,  OP_QUERY, '0, '0, REG_NUM_HASHES,  17'd16,      1'b0, '0},
    '{ROW_CFG,  OP_QUERY, '0, '0, REG_FILTER_BITS, 17'd0,       1'b0, '0},
    '{ROW_ITEM, OP_QUERY, 32'h5555_5555, 32'hAAAA_AAAA, '0, '0, 1'b0, '0},
    '{ROW_ITEM, OP_ADD,   32'h5555_5555, 32'hAAAA_AAAA, '0, '0, 1'b0, '0},
    '{ROW_CFG,  OP_QUERY, '0, '0, REG_FILTER_BITS, 17'd15,      1'b0, '0},
    '{ROW_ITEM, OP_QUERY, 32'h0000_0000, 32'h0000_0000, '0, '0, 1'b0, '0},
    '{ROW_CFG,  OP_QUERY, '0, '0, REG_FILTER_BITS, 17'h1_FFFF,  1'b0, '0},
    '{ROW_ITEM, OP_ADD,   32'hDEAD_BEEF, 32'h0BAD_F00D, '0, '0, 1'b0, '0},
    '{ROW_CFG,  OP_QUERY, '0, '0, REG_NUM_HASHES,  17'd17,      1'b0, '0},
    '{ROW_ITEM, OP_QUERY, 32'hDEAD_BEEF, 32'h0BAD_F00D, '0, '0, 1'b0, '0},
    '{ROW_CFG,  OP_QUERY, '0, '0, REG_NUM_HASHES,  17'd1,       1'b0, '0},
    '{ROW_CFG,  OP_QUERY, '0, '0, REG_FILTER_BITS, 17'd16,      1'b0, '0},
    '{ROW_ITEM, OP_QUERY, 32'h0000_000F, 32'h0000_0000, '0, '0, 1'b0, '0},
    '{ROW_CFG,  OP_QUERY, '0, '0, REG_NUM_HASHES,  17'd3,       1'b0, '0},
    '{ROW_CFG,  OP_QUERY, '0, '0, REG_FILTER_BITS, 17'h1_0000,  1'b0, '0},
    '{ROW_ITEM, OP_ADD,   32'h7FFF_FFFF, 32'h8000_0000, '0, '0, 1'b0, '0},
    '{ROW_ITEM, OP_QUERY, 32'h7FFF_FFFF, 32'h8000_0000, '0, '0, 1'b0, '0}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  pbf_in_if  req_if ();
  pbf_out_if rsp_if ();

  partitioned_bloom_filter u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (req_if),
    .out_o      (rsp_if)
  );

  // Shadow filter state
  bit                       shadow_store [MAX_BITS];
  logic [COUNT_W-1:0]       shadow_count;
  logic [NUM_HASHES_W-1:0]  shadow_num_hashes;
  logic [FILTER_BITS_W-1:0] shadow_filter_bits;

  lookup_result_t pending_lookups [$];
  logic [63:0]    key_pool [$];

  int          src_idle_pct  = 0;
  int          snk_stall_pct = 0;
  int          hold_off_left = 0;
  int          mismatch_cnt  = 0;
  int unsigned cycle_cnt     = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic lookup_result_t predict_lookup(input logic op,
                                                    input logic [HASH_W-1:0] a,
                                                    input logic [HASH_W-1:0] b);
    int unsigned    k;
    int unsigned    bits;
    logic [31:0]    slot;
    logic [31:0]    h;
    int unsigned    bit_idx [MAX_PROBES];
    bit             all_set;
    lookup_result_t res;
    k = 32'(shadow_num_hashes);
    bits = 32'(shadow_filter_bits);
    if (k < 1) k = 1;
    if (k > MAX_PROBES) k = MAX_PROBES;
    if (bits < MIN_BITS) bits = MIN_BITS;
    if (bits > MAX_BITS) bits = MAX_BITS;
    slot = bits / k;
    if (slot == 0) slot = 1;
    all_set = 1'b1;
    for (int unsigned i = 0; i < k; i++) begin
      if (i == 0) h = a;
      else if (i == 1) h = b;
      else h = b + a + 32'(i);
      bit_idx[i] = i * slot + h % slot;
      if (!shadow_store[bit_idx[i]]) all_set = 1'b0;
    end
    if (op == OP_QUERY) begin
      res.outcome = all_set;
    end else if (all_set) begin
      res.outcome = 1'b0;
    end else begin
      for (int unsigned i = 0; i < k; i++) shadow_store[bit_idx[i]] = 1'b1;
      if (shadow_count != '1) shadow_count++;
      res.outcome = 1'b1;
    end
    res.added_total = shadow_count;
    return res;
  endfunction

  function automatic logic [HASH_W-1:0] rand_hash();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    case (idx)
      REG_NUM_HASHES:  shadow_num_hashes  = data[NUM_HASHES_W-1:0];
      REG_FILTER_BITS: shadow_filter_bits = data;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic drive_item(input logic op, input logic [HASH_W-1:0] a,
                            input logic [HASH_W-1:0] b, input bit known,
                            input lookup_result_t golden);
    lookup_result_t res;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid  <= 1'b1;
    req_if.op     <= op;
    req_if.hash_a <= a;
    req_if.hash_b <= b;
    do @(posedge clk_i); while (!req_if.ready);
    res = predict_lookup(op, a, b);
    pending_lookups.push_back(known ? golden : res);
  endtask

  // Drop the request and let every outstanding lookup come back
  task automatic wait_drained();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk_i);
  endtask

  function automatic void score_result(input logic outcome, input logic [COUNT_W-1:0] total);
    lookup_result_t want;
    if (pending_lookups.size() == 0) begin
      mismatch_cnt++;
      if (mismatch_cnt <= MAX_REPORTS)
        $display("unexpected transaction: outcome %0b added_total %0d", outcome, total);
      return;
    end
    want = pending_lookups.pop_front();
    if (want.outcome !== outcome || want.added_total !== total) begin
      mismatch_cnt++;
      if (mismatch_cnt <= MAX_REPORTS)
        $display("result mismatch: expected outcome %0b added_total %0d, got %0b %0d",
                 want.outcome, want.added_total, outcome, total);
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) score_result(rsp_if.outcome, rsp_if.added_total);
  end

  // Result side: random stalls, or a long hold-off when requested
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_left > 0) begin
        rsp_if.ready <= 1'b0;
        hold_off_left--;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
      end
    end
  end

  initial begin
    while (cycle_cnt < TIMEOUT_CYCLES) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    stim_row_t   row;
    logic [63:0] key;
    logic        op;
    logic [31:0] a;
    logic [31:0] b;
    int          pick;
    logic [CFG_DATA_W-1:0] nh;
    logic [CFG_DATA_W-1:0] fb;

    req_if.valid  = 1'b0;
    req_if.op     = OP_QUERY;
    req_if.hash_a = '0;
    req_if.hash_b = '0;
    cfg_we        = 1'b0;
    cfg_idx       = REG_NUM_HASHES;
    cfg_data      = '0;
    foreach (shadow_store[i]) shadow_store[i] = 1'b0;
    shadow_count       = '0;
    shadow_num_hashes  = NUM_HASHES_RST;
    shadow_filter_bits = FILTER_BITS_RST;

    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      if (row.kind == ROW_CFG) begin
        wait_drained();
        write_reg(row.reg_idx, row.reg_data);
      end else begin
        drive_item(row.op, row.hash_a, row.hash_b, row.known, row.golden);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      case (p)
        0: begin nh = 17'd4;  fb = 17'h1_0000; end
        1: begin nh = 17'd1;  fb = 17'd16;     end
        2: begin nh = 17'd16; fb = 17'd256;    end
        3: begin nh = 17'd31; fb = 17'h1_FFFF; end
        4: begin nh = 17'd0;  fb = 17'd0;      end
        default: begin
          nh = CFG_DATA_W'($urandom_range(0, 31));
          fb = $urandom_range(0, 1) ? CFG_DATA_W'($urandom_range(0, 17'h1_FFFF))
                                    : CFG_DATA_W'($urandom_range(16, 1024));
        end
      endcase
      write_reg(REG_NUM_HASHES, nh);
      write_reg(REG_FILTER_BITS, fb);
      case (p % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 66; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 66; end
        default: begin src_idle_pct = 30; snk_stall_pct = 30; end
      endcase
      // long output stall with requests still offered
      if (p == 2) hold_off_left = HOLD_OFF_CYCLES;
      key_pool.delete();

      repeat (ITEMS_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        if (key_pool.size() == 0 || pick < 35) begin
          op = OP_ADD;
          a  = rand_hash();
          b  = rand_hash();
          key_pool.push_back({a, b});
          if (key_pool.size() > KEY_POOL_DEPTH) void'(key_pool.pop_front());
        end else begin
          key = key_pool[$urandom_range(0, key_pool.size() - 1)];
          a   = key[63:32];
          b   = key[31:0];
          if (pick < 60) begin
            op = OP_QUERY;
          end else if (pick < 75) begin
            op = OP_ADD;
          end else if (pick < 88) begin
            // near miss: one hash bit off a known key
            op = OP_QUERY;
            if ($urandom_range(0, 1)) a = a ^ (32'h1 << $urandom_range(0, 31));
            else b = b ^ (32'h1 << $urandom_range(0, 31));
          end else begin
            op = $urandom_range(0, 1) ? OP_ADD : OP_QUERY;
            a  = rand_hash();
            b  = rand_hash();
          end
        end
        drive_item(op, a, b, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_lookups.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/pbf_pkg.sv
rtl/pbf_if.sv
rtl/pbf_div.sv
rtl/pbf_datapath.sv
rtl/pbf_ctrl.sv
rtl/partitioned_bloom_filter.sv
sim/partitioned_bloom_filter_test.sv
